### rtl/status_led_blink_pattern_core_assert.svh
// Assertion macros for the checker file of the status LED pattern core.
// Depends on nothing; included by slbp_check, which carries the concurrent assertions.
`ifndef STATUS_LED_BLINK_PATTERN_CORE_ASSERT_SVH
`define STATUS_LED_BLINK_PATTERN_CORE_ASSERT_SVH

// Checked at every rising clock edge while reset is released.
`define SLBP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SLBP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/slbp_pkg.sv
// Shared types and timing constants for the status LED pattern core.
// Depends on nothing; used by slbp_step and status_led_blink_pattern_core.
package slbp_pkg;

    localparam int MODE_W = 3;
    localparam int STEP_W = 16;
    localparam int TIME_W = 32;
    localparam int MS_W   = 11;

    typedef logic [MS_W-1:0]   t_ms;
    typedef logic [TIME_W-1:0] t_time;

    // Display modes, same encoding as the mode ports.
    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL      = 3'd0,
        MODE_LOW_BATTERY = 3'd1,
        MODE_FAULT       = 3'd2,
        MODE_ESTOP       = 3'd3,
        MODE_UPPER_LINK  = 3'd4,
        MODE_CAL_RUNNING = 3'd5,
        MODE_CAL_OK      = 3'd6,
        MODE_CAL_APPLIED = 3'd7
    } t_mode;

    // Transaction kinds on the func field.
    localparam logic FUNC_TICK     = 1'b0;
    localparam logic FUNC_SET_MODE = 1'b1;

    // Blink period and on-time per mode, in milliseconds.
    localparam t_ms NORMAL_PERIOD = 11'd1000;
    localparam t_ms NORMAL_ON     = 11'd500;
    localparam t_ms ALERT_PERIOD  = 11'd200;
    localparam t_ms ALERT_ON      = 11'd100;
    localparam t_ms LINK_PERIOD   = 11'd600;
    localparam t_ms LINK_ON       = 11'd300;

    // Calibration OK: solid on for a fixed hold time.
    localparam t_ms CAL_OK_HOLD   = 11'd2000;

    // Calibration applied: a number of double flashes, each in its own frame.
    localparam t_ms CAL_APPLY_FRAME = 11'd600;
    localparam int  CAL_APPLY_COUNT = 3;
    localparam t_ms CAL_APPLY_END   = t_ms'(CAL_APPLY_COUNT * CAL_APPLY_FRAME);
    localparam t_ms FLASH_LEN       = 11'd100;

    // Architectural state of the pattern generator.
    typedef struct packed {
        t_mode mode;
        t_time blink_tick;
        t_time time_in_mode;
        t_ms   period;
        t_ms   on_time;
        logic  led;
    } t_state;

endpackage

### rtl/slbp_step.sv
// Next-state logic of the status LED pattern core for one transaction.
// Depends on slbp_pkg; instantiated by status_led_blink_pattern_core.
module slbp_step (
    input  logic                          i_func,
    input  logic [slbp_pkg::STEP_W-1:0]   i_step_ms,
    input  logic [slbp_pkg::MODE_W-1:0]   i_new_mode,
    input  slbp_pkg::t_state              i_state,
    output slbp_pkg::t_state              o_state
);

    logic [slbp_pkg::TIME_W:0]   time_sum;
    slbp_pkg::t_time             time_sat;
    slbp_pkg::t_time             tick_add;
    slbp_pkg::t_ms               sel_period;
    slbp_pkg::t_ms               sel_on;
    logic                        cal_done;
    slbp_pkg::t_ms               cal_time;
    slbp_pkg::t_ms               phase;
    slbp_pkg::t_time             tick_pre;
    slbp_pkg::t_time             tick_wrap;
    slbp_pkg::t_time             period_ext;
    slbp_pkg::t_time             on_ext;
    slbp_pkg::t_mode             req_mode;

    // Both counters advance by the step; time in mode saturates.
    always_comb begin
        time_sum = {1'b0, i_state.time_in_mode} + {{(slbp_pkg::TIME_W+1-slbp_pkg::STEP_W){1'b0}},
                                                   i_step_ms};
        time_sat = time_sum[slbp_pkg::TIME_W] ? '1 : time_sum[slbp_pkg::TIME_W-1:0];
        tick_add = i_state.blink_tick
                 + {{(slbp_pkg::TIME_W-slbp_pkg::STEP_W){1'b0}}, i_step_ms};
    end

    // Phase within a double-flash frame; only used below the end time, so it fits 11 bits.
    always_comb begin
        cal_time = time_sat[slbp_pkg::MS_W-1:0];
        if (cal_time >= slbp_pkg::t_ms'(2 * slbp_pkg::CAL_APPLY_FRAME)) begin
            phase = cal_time - slbp_pkg::t_ms'(2 * slbp_pkg::CAL_APPLY_FRAME);
        end else if (cal_time >= slbp_pkg::CAL_APPLY_FRAME) begin
            phase = cal_time - slbp_pkg::CAL_APPLY_FRAME;
        end else begin
            phase = cal_time;
        end
    end

    // Timing selection by mode; the calibration-done modes time out back to normal.
    always_comb begin
        sel_period = i_state.period;
        sel_on     = i_state.on_time;
        cal_done   = 1'b0;
        case (i_state.mode)
            slbp_pkg::MODE_NORMAL: begin
                sel_period = slbp_pkg::NORMAL_PERIOD;
                sel_on     = slbp_pkg::NORMAL_ON;
            end
            slbp_pkg::MODE_LOW_BATTERY, slbp_pkg::MODE_FAULT,
            slbp_pkg::MODE_ESTOP, slbp_pkg::MODE_CAL_RUNNING: begin
                sel_period = slbp_pkg::ALERT_PERIOD;
                sel_on     = slbp_pkg::ALERT_ON;
            end
            slbp_pkg::MODE_UPPER_LINK: begin
                sel_period = slbp_pkg::LINK_PERIOD;
                sel_on     = slbp_pkg::LINK_ON;
            end
            slbp_pkg::MODE_CAL_OK: begin
                if (time_sat >= {{(slbp_pkg::TIME_W-slbp_pkg::MS_W){1'b0}},
                                 slbp_pkg::CAL_OK_HOLD}) begin
                    cal_done = 1'b1;
                end else begin
                    sel_period = slbp_pkg::CAL_OK_HOLD;
                    sel_on     = slbp_pkg::CAL_OK_HOLD;
                end
            end
            slbp_pkg::MODE_CAL_APPLIED: begin
                if (time_sat >= {{(slbp_pkg::TIME_W-slbp_pkg::MS_W){1'b0}},
                                 slbp_pkg::CAL_APPLY_END}) begin
                    cal_done = 1'b1;
                end else begin
                    // Lit in the first and third slot of each frame.
                    sel_period = slbp_pkg::FLASH_LEN;
                    sel_on = (phase < slbp_pkg::FLASH_LEN
                              || (phase >= slbp_pkg::t_ms'(2 * slbp_pkg::FLASH_LEN)
                                  && phase < slbp_pkg::t_ms'(3 * slbp_pkg::FLASH_LEN)))
                             ? slbp_pkg::FLASH_LEN : '0;
                end
            end
            default: begin
                sel_period = slbp_pkg::NORMAL_PERIOD;
                sel_on     = slbp_pkg::NORMAL_ON;
            end
        endcase
    end

    // Wrap the blink tick by one period and derive the LED level.
    always_comb begin
        tick_pre   = cal_done ? '0 : tick_add;
        period_ext = {{(slbp_pkg::TIME_W-slbp_pkg::MS_W){1'b0}}, sel_period};
        on_ext     = {{(slbp_pkg::TIME_W-slbp_pkg::MS_W){1'b0}}, sel_on};
        tick_wrap  = (tick_pre >= period_ext) ? tick_pre - period_ext : tick_pre;
    end

    // Assemble the next state for either transaction kind.
    always_comb begin
        req_mode = slbp_pkg::t_mode'(i_new_mode);
        o_state  = i_state;
        if (i_func == slbp_pkg::FUNC_SET_MODE) begin
            if (req_mode != i_state.mode) begin
                o_state.mode         = req_mode;
                o_state.time_in_mode = '0;
                o_state.blink_tick   = '0;
            end
        end else begin
            o_state.mode         = cal_done ? slbp_pkg::MODE_NORMAL : i_state.mode;
            o_state.time_in_mode = cal_done ? '0 : time_sat;
            o_state.blink_tick   = tick_wrap;
            o_state.period       = sel_period;
            o_state.on_time      = sel_on;
            o_state.led          = (sel_on >= sel_period) ? 1'b1 : (tick_wrap < on_ext);
        end
    end

endmodule

### rtl/status_led_blink_pattern_core.sv
// Top level of the status LED pattern core: input register, state and result register.
// Depends on slbp_pkg and slbp_step.

// Each transaction is a time tick or a display-mode change and yields exactly one result
// with the LED level and the mode after it. One transaction is accepted per clock cycle
// while the input does not stall. A transaction is held in the input register, passes
// once through the next-state logic and is written to the result register, where its
// result is offered on the output. The input side stalls only while a result is held by a
// stalled output and another transaction already waits in the input register. After reset
// the mode is normal with a 1000 ms period and 500 ms on-time, and the LED is off.
module status_led_blink_pattern_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [slbp_pkg::STEP_W-1:0]   i_step_ms,
    input  logic [slbp_pkg::MODE_W-1:0]   i_new_mode,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_led_level,
    output logic [slbp_pkg::MODE_W-1:0]   o_mode_now
);

    logic                         r_in_vld;
    logic                         r_func;
    logic [slbp_pkg::STEP_W-1:0]  r_step_ms;
    logic [slbp_pkg::MODE_W-1:0]  r_new_mode;
    slbp_pkg::t_state             r_state;
    slbp_pkg::t_state             n_state;
    logic                         r_out_vld;
    logic                         r_led;
    logic [slbp_pkg::MODE_W-1:0]  r_mode;
    logic                         advance;
    logic                         in_take;

    // The held transaction moves on when the result register is free or being drained.
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func     <= i_func;
            r_step_ms  <= i_step_ms;
            r_new_mode <= i_new_mode;
        end
    end

    slbp_step u_step (
        .i_func     (r_func),
        .i_step_ms  (r_step_ms),
        .i_new_mode (r_new_mode),
        .i_state    (r_state),
        .o_state    (n_state)
    );

    // Generator state, updated once per processed transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= slbp_pkg::MODE_NORMAL;
            r_state.blink_tick   <= '0;
            r_state.time_in_mode <= '0;
            r_state.period       <= slbp_pkg::NORMAL_PERIOD;
            r_state.on_time      <= slbp_pkg::NORMAL_ON;
            r_state.led          <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_led  <= n_state.led;
            r_mode <= n_state.mode;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_led_level = r_led;
    assign o_mode_now  = r_mode;

endmodule

### rtl/slbp_check.sv
// Port-level checker for the status LED pattern core, attached by bind.
// Depends on slbp_pkg and status_led_blink_pattern_core_assert.svh.
`include "status_led_blink_pattern_core_assert.svh"

module slbp_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_func,
    input logic [slbp_pkg::STEP_W-1:0]   i_step_ms,
    input logic [slbp_pkg::MODE_W-1:0]   i_new_mode,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_led_level,
    input logic [slbp_pkg::MODE_W-1:0]   o_mode_now
);

    // A stalled input transaction stays offered with the same payload.
    `SLBP_ASSERT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall |=> i_in_valid && $stable({i_func, i_step_ms, i_new_mode}), "stalled transaction changed")

    // A pending result stays offered while the output side stalls.
    `SLBP_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `SLBP_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_led_level) && $stable(o_mode_now), "stalled result changed")

    // Input back-pressure only arises from a full, stalled result register.
    `SLBP_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled without output back-pressure")

    // Reset leaves no result on the output.
    `SLBP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind status_led_blink_pattern_core slbp_check u_slbp_check (.*);
